/* src/sobol_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sobol generator package
// Transfer types, command groups and action codes shared by the generator.
// ----------------------------------------------------------------------------
package sobol_pkg;

  // action codes
  localparam logic [1:0] ACT_LOAD   = 2'd0;
  localparam logic [1:0] ACT_EXPAND = 2'd1;
  localparam logic [1:0] ACT_GET    = 2'd2;
  localparam logic [1:0] ACT_SKIP   = 2'd3;

  typedef struct packed {
    logic [1:0]  action;
    logic [3:0]  dim_index;
    logic [4:0]  bit_index;
    logic [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [31:0] coordinate;
    logic [3:0]  coordinate_index;
    logic        last_of_point;
    logic        exhausted;
  } out_item_t;

  // direction table commands, one-cycle pulses at transfer
  typedef struct packed {
    logic        load;
    logic        expand;
    logic [3:0]  dim_index;
    logic [4:0]  bit_index;
    logic [31:0] value;
  } dir_cmd_t;

  // point unit commands, one-cycle pulses at transfer
  typedef struct packed {
    logic get;
    logic skip;
  } pt_cmd_t;

endpackage

/* src/sobol_dir_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sobol direction table
// Direction word memory with load, the expand sequencer (degree search,
// recurrence, left alignment) and a read port for point generation.
// ----------------------------------------------------------------------------
module sobol_dir_unit #(
  parameter int BITS     = 32,
  parameter int MAX_DIMS = 16,
  localparam int AW      = $clog2(MAX_DIMS * BITS)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  sobol_pkg::dir_cmd_t cmd_i,
  output logic                busy_o,
  input  logic [AW-1:0]       rd_addr_i,
  output logic [BITS-1:0]     rd_data_o
);

  localparam int IW = $clog2(BITS + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_DEG, S_RRD, S_RACC, S_RWR, S_ARD, S_AWR, S_FILL
  } state_t;

  state_t            state_r, state_nxt;
  logic [AW-1:0]     base_r, base_nxt;
  logic [31:0]       poly_r, poly_nxt;
  logic [31:0]       pshift_r, pshift_nxt;
  logic [4:0]        deg_r, deg_nxt;
  logic [IW-1:0]     i_r, i_nxt;
  logic [4:0]        k_r, k_nxt;
  logic [BITS-1:0]   acc_r, acc_nxt;

  logic [BITS-1:0]   mem [MAX_DIMS*BITS];
  logic [BITS-1:0]   rd_data_r;
  logic              we;
  logic [AW-1:0]     waddr, raddr, ex_raddr;
  logic [BITS-1:0]   wdata;
  logic [BITS-1:0]   sh, term;
  logic [IW-1:0]     amt;

  always_comb begin
    state_nxt  = state_r;
    base_nxt   = base_r;
    poly_nxt   = poly_r;
    pshift_nxt = pshift_r;
    deg_nxt    = deg_r;
    i_nxt      = i_r;
    k_nxt      = k_r;
    acc_nxt    = acc_r;
    we         = 1'b0;
    waddr      = AW'(32'(base_r) + 32'(i_r));
    wdata      = '0;
    ex_raddr   = AW'(32'(base_r) + 32'(i_r));
    amt        = IW'(BITS - 1) - i_r;
    sh         = rd_data_r << k_r;
    term       = '0;
    if (k_r == deg_r) begin
      term = rd_data_r ^ sh;
    end else if (poly_r[deg_r - k_r]) begin
      term = sh;
    end

    unique case (state_r)
      S_IDLE: begin
        if (cmd_i.load) begin
          we    = 1'b1;
          waddr = AW'(32'(cmd_i.dim_index) * BITS + 32'(cmd_i.bit_index));
          wdata = BITS'(cmd_i.value);
        end
        if (cmd_i.expand) begin
          base_nxt   = AW'(32'(cmd_i.dim_index) * BITS);
          poly_nxt   = cmd_i.value;
          pshift_nxt = cmd_i.value;
          deg_nxt    = '0;
          i_nxt      = '0;
          state_nxt  = (cmd_i.dim_index == 4'd0) ? S_FILL : S_DEG;
        end
      end
      S_FILL: begin
        // dimension 0: all ones, already aligned
        we    = 1'b1;
        wdata = BITS'(1) << amt;
        if (i_r == IW'(BITS - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          i_nxt = i_r + IW'(1);
        end
      end
      S_DEG: begin
        // one bit per cycle down to the top set bit
        if (pshift_r > 32'd1) begin
          pshift_nxt = pshift_r >> 1;
          deg_nxt    = deg_r + 5'd1;
        end else if (deg_r == 5'd0 || 32'(deg_r) >= BITS) begin
          i_nxt     = '0;
          state_nxt = S_ARD;
        end else begin
          i_nxt     = IW'(deg_r);
          k_nxt     = deg_r;
          acc_nxt   = '0;
          state_nxt = S_RRD;
        end
      end
      S_RRD: begin
        ex_raddr  = AW'(32'(base_r) + 32'(i_r) - 32'(k_r));
        state_nxt = S_RACC;
      end
      S_RACC: begin
        acc_nxt = acc_r ^ term;
        if (k_r == 5'd1) begin
          state_nxt = S_RWR;
        end else begin
          k_nxt     = k_r - 5'd1;
          state_nxt = S_RRD;
        end
      end
      S_RWR: begin
        we    = 1'b1;
        wdata = acc_r;
        if (i_r == IW'(BITS - 1)) begin
          i_nxt     = '0;
          state_nxt = S_ARD;
        end else begin
          i_nxt     = i_r + IW'(1);
          k_nxt     = deg_r;
          acc_nxt   = '0;
          state_nxt = S_RRD;
        end
      end
      S_ARD: begin
        state_nxt = S_AWR;
      end
      S_AWR: begin
        we    = 1'b1;
        wdata = rd_data_r << amt;
        if (i_r == IW'(BITS - 2)) begin
          state_nxt = S_IDLE;
        end else begin
          i_nxt     = i_r + IW'(1);
          state_nxt = S_ARD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    base_r   <= base_nxt;
    poly_r   <= poly_nxt;
    pshift_r <= pshift_nxt;
    deg_r    <= deg_nxt;
    i_r      <= i_nxt;
    k_r      <= k_nxt;
    acc_r    <= acc_nxt;
  end

  assign raddr = (state_r == S_IDLE) ? rd_addr_i : ex_raddr;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_data_r <= mem[raddr];
  end

  assign busy_o    = (state_r != S_IDLE);
  assign rd_data_o = rd_data_r;

endmodule

/* src/sobol_point_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sobol point unit
// Coordinate memory, point counter and read cursor; serves get and skip and
// builds each new point by read-modify-write over the coordinates.
// ----------------------------------------------------------------------------
module sobol_point_unit #(
  parameter int BITS     = 32,
  parameter int MAX_DIMS = 16,
  localparam int AW      = $clog2(MAX_DIMS * BITS),
  localparam int CW      = $clog2(MAX_DIMS + 1)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sobol_pkg::pt_cmd_t   cmd_i,
  input  logic [CW-1:0]        n_i,
  input  logic                 cfg_we_i,
  input  logic [CW-1:0]        cfg_n_i,
  output logic                 busy_o,
  output logic [AW-1:0]        dir_addr_o,
  input  logic [BITS-1:0]      dir_data_i,
  output logic                 res_valid_o,
  output sobol_pkg::out_item_t res_o
);

  localparam int DW  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int CBW = $clog2(BITS);

  typedef enum logic [2:0] {P_CLR, P_IDLE, P_NP, P_NPL, P_GRD} state_t;

  state_t          state_r, state_nxt;
  logic [BITS-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0]   cur_r, cur_nxt;
  logic [DW-1:0]   j_r, j_nxt;
  logic [CBW-1:0]  c_r, c_nxt;
  logic            pend_get_r, pend_get_nxt;
  logic            ov_r, ov_nxt;
  logic [3:0]      oidx_r, oidx_nxt;
  logic            olast_r, olast_nxt;
  logic            oexh_r, oexh_nxt;

  logic [BITS-1:0] mem [MAX_DIMS];
  logic [BITS-1:0] crd_r;
  logic            cwe;
  logic [DW-1:0]   cwaddr, craddr;
  logic [BITS-1:0] cwdata;

  logic [BITS-1:0] onehot;
  logic [CBW-1:0]  c_enc;
  logic            have_coord, need_np, do_get;
  logic [31:0]     cur32;
  logic [31:0]     coord32;

  // index of the lowest zero bit of the count
  always_comb begin
    onehot = ~cnt_r & (cnt_r + BITS'(1));
    c_enc  = '0;
    for (int b = 0; b < BITS; b++) begin
      if (onehot[b]) c_enc = c_enc | CBW'(b);
    end
  end

  assign have_coord = (cur_r < n_i);
  assign cur32      = 32'(cur_r);

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    cur_nxt      = cur_r;
    j_nxt        = j_r;
    c_nxt        = c_r;
    pend_get_nxt = pend_get_r;
    ov_nxt       = 1'b0;
    oidx_nxt     = '0;
    olast_nxt    = 1'b0;
    oexh_nxt     = 1'b0;
    cwe          = 1'b0;
    cwaddr       = j_r;
    cwdata       = crd_r ^ dir_data_i;
    craddr       = DW'(cur_r);
    need_np      = 1'b0;
    do_get       = 1'b0;

    // a dimension write also lands while the clear pass runs
    if (cfg_we_i) begin
      cur_nxt = cfg_n_i;
    end

    unique case (state_r)
      P_CLR: begin
        cwe    = 1'b1;
        cwdata = '0;
        if (32'(j_r) == MAX_DIMS - 1) begin
          j_nxt     = '0;
          state_nxt = P_IDLE;
        end else begin
          j_nxt = j_r + DW'(1);
        end
      end
      P_IDLE: begin
        do_get  = cmd_i.get & have_coord;
        need_np = (cmd_i.get & ~have_coord) | (cmd_i.skip & have_coord);
        if (need_np) begin
          if (&cnt_r) begin
            ov_nxt   = 1'b1;
            oexh_nxt = 1'b1;
          end else begin
            cnt_nxt      = cnt_r + BITS'(1);
            c_nxt        = c_enc;
            j_nxt        = '0;
            pend_get_nxt = cmd_i.get;
            state_nxt    = P_NP;
          end
        end
      end
      P_NP: begin
        // read entry j while writing back entry j-1
        craddr = j_r;
        cwaddr = j_r - DW'(1);
        cwe    = (j_r != '0);
        if (32'(j_r) + 32'd1 == 32'(n_i)) begin
          state_nxt = P_NPL;
        end else begin
          j_nxt = j_r + DW'(1);
        end
      end
      P_NPL: begin
        cwe       = 1'b1;
        cur_nxt   = '0;
        state_nxt = pend_get_r ? P_GRD : P_IDLE;
      end
      P_GRD: begin
        do_get    = 1'b1;
        state_nxt = P_IDLE;
      end
      default: state_nxt = P_IDLE;
    endcase

    if (do_get) begin
      ov_nxt    = 1'b1;
      oidx_nxt  = cur32[3:0];
      olast_nxt = (cur32 + 32'd1 == 32'(n_i));
      cur_nxt   = cur_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= P_CLR;
      cnt_r   <= '0;
      cur_r   <= CW'(1);
      j_r     <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      cur_r   <= cur_nxt;
      j_r     <= j_nxt;
      ov_r    <= ov_nxt;
    end
    c_r        <= c_nxt;
    pend_get_r <= pend_get_nxt;
    oidx_r     <= oidx_nxt;
    olast_r    <= olast_nxt;
    oexh_r     <= oexh_nxt;
  end

  always_ff @(posedge clk) begin
    if (cwe) begin
      mem[cwaddr] <= cwdata;
    end
    crd_r <= mem[craddr];
  end

  generate
    if (BITS >= 32) begin : g_wide
      assign coord32 = crd_r[BITS-1 -: 32];
    end else begin : g_narrow
      assign coord32 = {crd_r, {(32 - BITS){1'b0}}};
    end
  endgenerate

  assign dir_addr_o = AW'(32'(j_r) * BITS + 32'(c_r));
  assign busy_o     = (state_r != P_IDLE);

  assign res_valid_o            = ov_r;
  assign res_o.coordinate       = oexh_r ? 32'd0 : coord32;
  assign res_o.coordinate_index = oidx_r;
  assign res_o.last_of_point    = olast_r;
  assign res_o.exhausted        = oexh_r;

endmodule

/* src/sobol_sequence_generator_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sobol sequence generator, top level
// Gray-code Sobol points as unsigned 0.32 fractions, one coordinate per get.
// ----------------------------------------------------------------------------
// Usage:
//  - Commands transfer on a rising edge with start high and busy low.
//    Load writes one direction word, expand completes one dimension's table,
//    get returns the next coordinate, skip drops the rest of the point.
//  - cfg_we/cfg_wdata set the coordinates per point (clamped 1..MAX_DIMS);
//    write only while idle. The next get then starts a fresh point.
//  - Results show on out_data for exactly one cycle with out_strobe high;
//    the receiver cannot stall, so it must take every strobe.
//  - Load does not raise busy. A get from the current point strobes in the cycle
//    after transfer, busy stays low, so gets run one per cycle.
//  - A get or skip that opens a new point walks the coordinate memory by
//    read-modify-write over its n coordinates (P_NP, P_NPL), and a get then
//    strobes after P_GRD. Exhaustion strobes in the cycle after transfer.
//  - Expand is a sequencer on the direction memory: degree search (S_DEG),
//    the recurrence per entry (S_RRD, S_RACC, S_RWR) and left alignment
//    (S_ARD, S_AWR); dimension 0 is filled in S_FILL instead.
//  - After reset busy stays high while the coordinate memory is cleared
//    (P_CLR); the direction table is left unwritten.
// ----------------------------------------------------------------------------
module sobol_sequence_generator_top #(
  parameter int BITS     = 32,
  parameter int MAX_DIMS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  sobol_pkg::in_item_t  in_data,
  output logic                 out_strobe,
  output sobol_pkg::out_item_t out_data,
  input  logic                 cfg_we,
  input  logic [4:0]           cfg_wdata
);

  localparam int AW = $clog2(MAX_DIMS * BITS);
  localparam int CW = $clog2(MAX_DIMS + 1);

  logic                accept;
  logic                dir_busy, pt_busy;
  logic                dim_ok, bit_ok;
  sobol_pkg::dir_cmd_t dir_cmd;
  sobol_pkg::pt_cmd_t  pt_cmd;
  logic [AW-1:0]       dir_addr;
  logic [BITS-1:0]     dir_data;
  logic [CW-1:0]       n_r, n_nxt;
  logic [31:0]         cfg32;

  // clamp the written dimension to 1..MAX_DIMS
  always_comb begin
    cfg32 = 32'(cfg_wdata);
    if (cfg32 < 32'd1) begin
      n_nxt = CW'(1);
    end else if (cfg32 > 32'(MAX_DIMS)) begin
      n_nxt = CW'(MAX_DIMS);
    end else begin
      n_nxt = CW'(cfg32);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r <= CW'(1);
    end else if (cfg_we) begin
      n_r <= n_nxt;
    end
  end

  assign busy   = dir_busy | pt_busy;
  assign accept = start & ~busy;

  // out-of-range loads and expands are dropped here
  assign dim_ok = (32'(in_data.dim_index) < 32'(MAX_DIMS));
  assign bit_ok = (32'(in_data.bit_index) < 32'(BITS));

  always_comb begin
    dir_cmd.load      = accept & (in_data.action == sobol_pkg::ACT_LOAD) & dim_ok & bit_ok;
    dir_cmd.expand    = accept & (in_data.action == sobol_pkg::ACT_EXPAND) & dim_ok;
    dir_cmd.dim_index = in_data.dim_index;
    dir_cmd.bit_index = in_data.bit_index;
    dir_cmd.value     = in_data.value;
    pt_cmd.get        = accept & (in_data.action == sobol_pkg::ACT_GET);
    pt_cmd.skip       = accept & (in_data.action == sobol_pkg::ACT_SKIP);
  end

  sobol_dir_unit #(
    .BITS     (BITS),
    .MAX_DIMS (MAX_DIMS)
  ) u_dir (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_i     (dir_cmd),
    .busy_o    (dir_busy),
    .rd_addr_i (dir_addr),
    .rd_data_o (dir_data)
  );

  sobol_point_unit #(
    .BITS     (BITS),
    .MAX_DIMS (MAX_DIMS)
  ) u_point (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_i       (pt_cmd),
    .n_i         (n_r),
    .cfg_we_i    (cfg_we),
    .cfg_n_i     (n_nxt),
    .busy_o      (pt_busy),
    .dir_addr_o  (dir_addr),
    .dir_data_i  (dir_data),
    .res_valid_o (out_strobe),
    .res_o       (out_data)
  );

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sobol sequence generator testbench
// Sends load, expand, get and skip commands to the generator under random
// start gaps. A behavioural copy of the direction table and the Gray-code
// point update predicts every coordinate. Strobed results are checked field
// by field against the oldest outstanding coordinate.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int BITS          = 32;
  localparam int MAX_DIMS      = 16;
  // long enough for the longest expand to finish
  localparam int SETTLE_CYCLES = 700;
  localparam int PHASE_ITEMS   = 125;
  localparam int PHASES        = 8;

  // one row of the opening table; typed rows carry a coordinate that can
  // be worked out by hand (dimension 1, so index 0 and last set)
  typedef struct packed {
    sobol_pkg::in_item_t  cmd;
    logic                 typed;
    sobol_pkg::out_item_t want;
  } step_row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  sobol_pkg::in_item_t  in_data;
  logic                 out_strobe;
  sobol_pkg::out_item_t out_data;
  logic                 cfg_we;
  logic [4:0]           cfg_wdata;

  sobol_sequence_generator_top #(
    .BITS     (BITS),
    .MAX_DIMS (MAX_DIMS)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_strobe (out_strobe),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  // --------------------------------------------------------------------------
  // Predictor state: direction words, current point, Gray counter, cursor
  // --------------------------------------------------------------------------
  logic [BITS-1:0] dir_words   [MAX_DIMS][BITS];
  logic [BITS-1:0] coord_words [MAX_DIMS];
  logic [BITS-1:0] point_count;
  int unsigned     read_pos;
  int unsigned     dims_per_point;

  sobol_pkg::out_item_t due_coords [$];   // coordinates still to be strobed
  sobol_pkg::out_item_t oldest;
  int unsigned     mismatch_count = 0;
  step_row_t       opening_steps [$];
  logic [4:0]      phase_dims [PHASES] = '{5'd16, 5'd31, 5'd0, 5'd2,
                                           5'd17, 5'd1, 5'd5, 5'd9};

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Register value 0 means one coordinate, anything above MAX_DIMS means all
  function automatic int unsigned clamp_dims(input logic [4:0] v);
    if (v == 5'd0) return 1;
    if (v > MAX_DIMS) return MAX_DIMS;
    return v;
  endfunction

  // Complete one dimension's direction words from its polynomial, then
  // left-align entry i by BITS-1-i. Dimension 0 is all ones before aligning.
  task automatic expand_dim(input logic [3:0] dim, input logic [31:0] poly);
    int unsigned     deg;
    logic [BITS-1:0] w;
    deg = 0;
    for (int b = 1; b < 32; b++)
      if (poly[b]) deg = b;
    if (dim == 4'd0) begin
      for (int i = 0; i < BITS; i++) dir_words[0][i] = 'd1;
    end else if (deg > 0) begin
      for (int i = deg; i < BITS; i++) begin
        w = dir_words[dim][i-deg] ^ (dir_words[dim][i-deg] << deg);
        for (int k = 1; k < deg; k++)
          if (poly[deg-k]) w ^= dir_words[dim][i-k] << k;
        dir_words[dim][i] = w;
      end
    end
    for (int i = 0; i + 1 < BITS; i++)
      dir_words[dim][i] = dir_words[dim][i] << (BITS - 1 - i);
  endtask

  // Next Gray-code point: XOR in the word at the lowest zero bit of the
  // old count. Fails without change once the counter is all ones.
  task automatic advance_point(output bit ok);
    logic [BITS-1:0] rest;
    int unsigned     col;
    ok = 1'b0;
    if (point_count == '1) return;
    rest        = point_count;
    col         = 0;
    point_count = point_count + 1'b1;
    while (rest[0] && col + 1 < BITS) begin
      rest = rest >> 1;
      col++;
    end
    for (int d = 0; d < dims_per_point; d++)
      coord_words[d] ^= dir_words[d][col];
    read_pos = 0;
    ok       = 1'b1;
  endtask

  task automatic predict_command(input sobol_pkg::in_item_t cmd, output bit got,
                                 output sobol_pkg::out_item_t res);
    bit ok;
    got = 1'b0;
    res = '0;
    ok  = 1'b1;
    case (cmd.action)
      sobol_pkg::ACT_LOAD: begin
        dir_words[cmd.dim_index][cmd.bit_index] = cmd.value;
      end
      sobol_pkg::ACT_EXPAND: begin
        expand_dim(cmd.dim_index, cmd.value);
      end
      sobol_pkg::ACT_SKIP: begin
        // only a partly read point is dropped; exhaustion still reports
        if (read_pos < dims_per_point) advance_point(ok);
        if (!ok) begin
          got           = 1'b1;
          res.exhausted = 1'b1;
        end
      end
      sobol_pkg::ACT_GET: begin
        if (read_pos >= dims_per_point) advance_point(ok);
        got = 1'b1;
        if (!ok) begin
          res.exhausted = 1'b1;
        end else begin
          res.coordinate       = coord_words[read_pos];
          res.coordinate_index = 4'(read_pos);
          res.last_of_point    = (read_pos + 1 == dims_per_point);
          read_pos++;
        end
      end
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Driving: start and in_data change only right after a rising edge.
  // A command transfers at the first edge with busy low; busy is sampled
  // right after the edge, so it still holds its pre-edge value.
  // --------------------------------------------------------------------------
  task automatic issue(input sobol_pkg::in_item_t cmd, input bit typed,
                       input sobol_pkg::out_item_t want);
    bit                   got;
    sobol_pkg::out_item_t res;
    start   <= 1'b1;
    in_data <= cmd;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_command(cmd, got, res);
    if (typed) due_coords.push_back(want);
    else if (got) due_coords.push_back(res);
  endtask

  task automatic idle_for(input int unsigned cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // mostly back-to-back or short gaps, now and then a long one
  function automatic int unsigned pick_gap(input bit quiet);
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // wait for every outstanding coordinate, then for any expand or point
  // walk that produces no result to run out
  task automatic settle();
    start <= 1'b0;
    while (due_coords.size() != 0 || busy) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_dims(input logic [4:0] v);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    dims_per_point = clamp_dims(v);
    read_pos       = dims_per_point;   // next get opens a fresh point
    cfg_we    <= 1'b0;
  endtask

  // polynomial with x^deg on top and random lower terms; degree 0 gives
  // the zero or one polynomial, which only re-aligns
  function automatic logic [31:0] poly_of_degree(input int unsigned deg);
    logic [31:0] top;
    if (deg == 0) return 32'($urandom_range(0, 1));
    top = 32'd1 << deg;
    return top | ($urandom & (top - 32'd1));
  endfunction

  // Mostly gets and skips, which walk the sequence; loads and expands
  // reshape the table on the fly. All table entries are written by then.
  function automatic sobol_pkg::in_item_t random_cmd();
    sobol_pkg::in_item_t cmd;
    int unsigned         roll;
    int unsigned         deg;
    cmd.dim_index = 4'($urandom);
    cmd.bit_index = 5'($urandom);
    cmd.value     = $urandom;
    roll          = $urandom_range(99);
    if (roll < 72) begin
      cmd.action = sobol_pkg::ACT_GET;
    end else if (roll < 82) begin
      cmd.action = sobol_pkg::ACT_SKIP;
    end else if (roll < 95) begin
      cmd.action = sobol_pkg::ACT_LOAD;
      if (roll == 93) cmd.value = '0;
      if (roll == 94) cmd.value = '1;
    end else begin
      cmd.action = sobol_pkg::ACT_EXPAND;
      deg        = (roll == 99) ? $urandom_range(0, 31) : $urandom_range(0, 6);
      cmd.value  = poly_of_degree(deg);
    end
    return cmd;
  endfunction

  function automatic step_row_t row(input logic [1:0] act, input int unsigned dim,
                                    input int unsigned bitn, input logic [31:0] val,
                                    input bit typed, input logic [31:0] coord);
    step_row_t r;
    r.cmd.action         = act;
    r.cmd.dim_index      = 4'(dim);
    r.cmd.bit_index      = 5'(bitn);
    r.cmd.value          = val;
    r.typed              = typed;
    r.want.coordinate    = coord;
    r.want.coordinate_index = '0;
    r.want.last_of_point = 1'b1;
    r.want.exhausted     = 1'b0;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Result check: every strobe is taken, so the oldest entry must match
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (due_coords.size() == 0) begin
        $error("unexpected result: coordinate %h index %0d last %b exhausted %b",
               out_data.coordinate, out_data.coordinate_index,
               out_data.last_of_point, out_data.exhausted);
        mismatch_count++;
      end else begin
        oldest = due_coords.pop_front();
        if (out_data.coordinate !== oldest.coordinate) begin
          $error("coordinate: expected %h, actual %h",
                 oldest.coordinate, out_data.coordinate);
          mismatch_count++;
        end
        if (out_data.coordinate_index !== oldest.coordinate_index) begin
          $error("coordinate_index: expected %0d, actual %0d",
                 oldest.coordinate_index, out_data.coordinate_index);
          mismatch_count++;
        end
        if (out_data.last_of_point !== oldest.last_of_point) begin
          $error("last_of_point: expected %b, actual %b",
                 oldest.last_of_point, out_data.last_of_point);
          mismatch_count++;
        end
        if (out_data.exhausted !== oldest.exhausted) begin
          $error("exhausted: expected %b, actual %b",
                 oldest.exhausted, out_data.exhausted);
          mismatch_count++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // Exhaustion needs 2^32-1 points and cannot be reached in a run of this
  // length; the predictor still covers it.
  // --------------------------------------------------------------------------
  initial begin
    sobol_pkg::in_item_t cmd;
    int unsigned         deg;

    start     <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    rst_n     <= 1'b0;

    foreach (coord_words[i]) coord_words[i] = '0;
    point_count    = '0;
    dims_per_point = 1;
    read_pos       = 1;

    // Opening table, reset dimension of 1. Dimension 0 aligned words are
    // 1<<31, 1<<30, 1<<29, so the first points are easy to follow.
    opening_steps.push_back(row(sobol_pkg::ACT_EXPAND, 0, 0, 32'hFFFF_FFFF, 1'b0, '0));
    opening_steps.push_back(row(sobol_pkg::ACT_GET, 0, 0, 32'h0, 1'b1, 32'h8000_0000));
    opening_steps.push_back(row(sobol_pkg::ACT_GET, 15, 31, 32'hFFFF_FFFF, 1'b1,
                                32'hC000_0000));
    // skip with the point fully read: nothing happens
    opening_steps.push_back(row(sobol_pkg::ACT_SKIP, 0, 0, 32'h0000_0000, 1'b0, '0));
    opening_steps.push_back(row(sobol_pkg::ACT_GET, 0, 0, 32'h0, 1'b1, 32'h4000_0000));
    opening_steps.push_back(row(sobol_pkg::ACT_GET, 0, 0, 32'h0, 1'b1, 32'h6000_0000));
    // dimension 1: x^2+x+1 with initial numbers 1 and 3
    opening_steps.push_back(row(sobol_pkg::ACT_LOAD, 1, 0, 32'h0000_0001, 1'b0, '0));
    opening_steps.push_back(row(sobol_pkg::ACT_LOAD, 1, 1, 32'h0000_0003, 1'b0, '0));
    opening_steps.push_back(row(sobol_pkg::ACT_EXPAND, 1, 0, 32'h0000_0007, 1'b0, '0));
    // repeated expand with the zero polynomial: realigns only
    opening_steps.push_back(row(sobol_pkg::ACT_EXPAND, 1, 0, 32'h0000_0000, 1'b0, '0));
    // dimension 2: degree one, then the one polynomial
    opening_steps.push_back(row(sobol_pkg::ACT_LOAD, 2, 0, 32'hFFFF_FFFF, 1'b0, '0));
    opening_steps.push_back(row(sobol_pkg::ACT_EXPAND, 2, 0, 32'h0000_0003, 1'b0, '0));
    opening_steps.push_back(row(sobol_pkg::ACT_EXPAND, 2, 0, 32'h0000_0001, 1'b0, '0));
    // highest addresses with zero and all-ones words
    opening_steps.push_back(row(sobol_pkg::ACT_LOAD, 15, 31, 32'h0000_0000, 1'b0, '0));
    opening_steps.push_back(row(sobol_pkg::ACT_LOAD, 15, 31, 32'hFFFF_FFFF, 1'b0, '0));
    opening_steps.push_back(row(sobol_pkg::ACT_GET, 0, 0, 32'h0, 1'b1, 32'hE000_0000));
    opening_steps.push_back(row(sobol_pkg::ACT_GET, 0, 0, 32'h0000_0000, 1'b0, '0));
    opening_steps.push_back(row(sobol_pkg::ACT_SKIP, 0, 0, 32'hFFFF_FFFF, 1'b0, '0));

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    // lets the coordinate memory clear finish
    settle();

    foreach (opening_steps[i]) begin
      issue(opening_steps[i].cmd, opening_steps[i].typed, opening_steps[i].want);
      idle_for(pick_gap(1'b0));
    end

    // Fill the remaining dimensions so no unwritten word is ever read:
    // load m_0..m_{deg-1}, then expand writes the rest.
    for (int d = 3; d < MAX_DIMS; d++) begin
      deg = $urandom_range(1, 7);
      for (int b = 0; b < deg; b++) begin
        cmd.action    = sobol_pkg::ACT_LOAD;
        cmd.dim_index = 4'(d);
        cmd.bit_index = 5'(b);
        cmd.value     = $urandom | 32'd1;
        issue(cmd, 1'b0, '0);
        idle_for(pick_gap(1'b0));
      end
      cmd.action    = sobol_pkg::ACT_EXPAND;
      cmd.bit_index = 5'($urandom);
      cmd.value     = poly_of_degree(deg);
      issue(cmd, 1'b0, '0);
      idle_for(pick_gap(1'b0));
    end

    // Random phases, each under its own dimension setting; the first one
    // runs without start gaps. Now and then the sender holds off until
    // every outstanding coordinate is back.
    for (int p = 0; p < PHASES; p++) begin
      write_dims(p < 6 ? phase_dims[p] : 5'($urandom_range(1, 31)));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        issue(random_cmd(), 1'b0, '0);
        if ($urandom_range(49) == 0) begin
          start <= 1'b0;
          do @(posedge clk); while (due_coords.size() != 0);
        end else begin
          idle_for(pick_gap(p == 0));
        end
      end
    end

    settle();
    if (mismatch_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  // Safety net: far beyond the slowest correct run
  initial begin
    #20_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
